### rtl/slerp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slerp_pkg;

    // Fixed-point format of the ports and iteration count of the angle units.
    localparam int FRAC_BITS        = 14;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int IW               = (ANGLE_ITERATIONS > 1) ? $clog2(ANGLE_ITERATIONS) : 1;

    // Depth of the queue between front end and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Quotient bits of the weight division; weights stay well below 2^38.
    localparam int QB = 38;

    // Rescaling of the raw dot product to Q.30.
    localparam int SH_L = (2 * FRAC_BITS <= 30) ? 30 - 2 * FRAC_BITS : 0;
    localparam int SH_R = (2 * FRAC_BITS > 30) ? 2 * FRAC_BITS - 30 : 0;
    localparam int MW   = 34 + SH_L;

    localparam logic [30:0]        QONE       = 31'h4000_0000;
    localparam logic [30:0]        NEAR_LIMIT = 31'd1073742;
    localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;

    localparam int OUT_HI_I = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
    localparam int OUT_LO_I = (FRAC_BITS >= 15) ? -32768 : -(1 << FRAC_BITS);
    localparam logic signed [63:0] OUT_HI = 64'(OUT_HI_I);
    localparam logic signed [63:0] OUT_LO = 64'(OUT_LO_I);

    typedef struct packed {
        logic signed [15:0] from_w;
        logic signed [15:0] from_x;
        logic signed [15:0] from_y;
        logic signed [15:0] from_z;
        logic signed [15:0] target_w;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
        logic [14:0]        blend;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_w;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
    } out_t;

    // One classified transaction as the front end hands it to the back end.
    // Component index 0 is w, then x, y, z.
    typedef struct packed {
        logic [3:0][15:0] a;     // start quaternion
        logic [3:0][16:0] b;     // end quaternion, negated for the shorter arc
        logic [30:0]      c;     // |dot| in Q.30, saturated to one
        logic [60:0]      n;     // 2^60 - c^2, radicand of sin(theta)
        logic [30:0]      r30;   // clamped ratio in Q.30
        logic             lin;   // near-parallel: use linear weights
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQRT,
        B_SEL,
        B_VEC,
        B_MULA,
        B_MULB,
        B_ROT,
        B_DINIT,
        B_DIV,
        B_WGT,
        B_MAC,
        B_OUT
    } back_state_t;

    // Arctangent of 2^-i in Q.30 radians.
    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            5'd24:   v = 30'd64;
            5'd25:   v = 30'd32;
            5'd26:   v = 30'd16;
            5'd27:   v = 30'd8;
            5'd28:   v = 30'd4;
            5'd29:   v = 30'd2;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/quaternion_slerp.sv
// Spherical linear interpolation between two unit quaternions, Q2.14.
//
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. item carries both quaternions and the blend ratio.
// Output channel: done is high for exactly one cycle while result holds the
// interpolated quaternion; the receiver cannot stall it, so there is no
// backpressure and each result must be captured in that cycle.
//
// A three-stage front end forms the dot product, folds its sign so that the
// shorter arc is taken, clamps the ratio and flags near-parallel pairs. It
// takes a transaction every cycle while busy is low and feeds a four-entry
// queue. One back-end sequencer then works through square root, angle
// CORDIC and two sine CORDICs, a divider for both weights and a weighted
// sum, one transaction at a time; near-parallel pairs go from the square
// root straight to the weighted sum.
// busy rises when queue entries plus front-end transactions reach four.
// Reset empties the pipeline and queue and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_slerp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire slerp_pkg::in_t   item,
    output logic                  busy,
    output logic                  done,
    output slerp_pkg::out_t       result
);

    logic                              accept;
    logic                              push;
    slerp_pkg::job_t                   push_job;
    logic [1:0]                        inflight;
    slerp_pkg::job_t                   head;
    logic                              head_valid;
    logic                              pop;
    logic [slerp_pkg::QCNT_W-1:0]      count;
    logic [slerp_pkg::QCNT_W:0]        occupancy;

    // Everything in the front end is already counted against the queue, so
    // the queue can never overflow even with no back-end progress.
    assign occupancy = (slerp_pkg::QCNT_W + 1)'(count) + (slerp_pkg::QCNT_W + 1)'(inflight);
    assign busy      = (occupancy >= (slerp_pkg::QCNT_W + 1)'(slerp_pkg::QUEUE_DEPTH));
    assign accept    = start && !busy;

    slerp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .push     (push),
        .job      (push_job),
        .inflight (inflight)
    );

    slerp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .count      (count)
    );

    slerp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (head_valid),
        .q_head  (head),
        .q_pop   (pop),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

### rtl/slerp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module slerp_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire slerp_pkg::in_t  item,
    output logic                 push,
    output slerp_pkg::job_t      job,
    output logic [1:0]           inflight
);

    // Stage A: the four products of the dot product.
    logic                     va_reg;
    logic signed [31:0]       prod_reg [4];
    logic [3:0][15:0]         a_reg;
    logic [3:0][15:0]         tb_reg;
    logic [14:0]              blend_reg;

    // Stage B: sign fold, rescale, ratio clamp.
    logic                     vb_reg;
    slerp_pkg::job_t          jb_reg;
    slerp_pkg::job_t          jb_next;

    // Stage C: radicand of the sine.
    logic                     vc_reg;
    slerp_pkg::job_t          jc_reg;
    slerp_pkg::job_t          jc_next;

    logic signed [33:0]       dot;
    logic                     neg;
    logic [33:0]              mag;
    logic [slerp_pkg::MW-1:0] mag_sc;
    logic [30:0]              c_v;
    logic [30:0]              r_lim;
    logic [30:0]              r_c;
    logic signed [16:0]       tx [4];
    logic [61:0]              csq;

    always_comb
    begin
        dot = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        neg = dot[33];
        mag = neg ? 34'(-dot) : 34'(dot);
        mag_sc = (slerp_pkg::MW'(mag) << slerp_pkg::SH_L) >> slerp_pkg::SH_R;
        c_v = (mag_sc > slerp_pkg::MW'(slerp_pkg::QONE)) ? slerp_pkg::QONE : mag_sc[30:0];
        r_lim = 31'(1) << slerp_pkg::FRAC_BITS;
        r_c = (31'(blend_reg) > r_lim) ? r_lim : 31'(blend_reg);
        jb_next.a   = a_reg;
        jb_next.c   = c_v;
        jb_next.n   = '0;
        jb_next.r30 = r_c << (30 - slerp_pkg::FRAC_BITS);
        jb_next.lin = ((slerp_pkg::QONE - c_v) <= slerp_pkg::NEAR_LIMIT);
        for (int k = 0; k < 4; k++)
        begin
            tx[k] = 17'($signed(tb_reg[k]));
            jb_next.b[k] = neg ? 17'(-tx[k]) : tx[k];
        end
    end

    always_comb
    begin
        csq = 62'(jb_reg.c) * 62'(jb_reg.c);
        jc_next = jb_reg;
        jc_next.n = 61'((62'(1) << 60) - csq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= accept;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg[0] <= item.from_w * item.target_w;
            prod_reg[1] <= item.from_x * item.target_x;
            prod_reg[2] <= item.from_y * item.target_y;
            prod_reg[3] <= item.from_z * item.target_z;
            a_reg       <= {item.from_z, item.from_y, item.from_x, item.from_w};
            tb_reg      <= {item.target_z, item.target_y, item.target_x, item.target_w};
            blend_reg   <= item.blend;
        end
        if (va_reg)
        begin
            jb_reg <= jb_next;
        end
        if (vb_reg)
        begin
            jc_reg <= jc_next;
        end
    end

    assign push     = vc_reg;
    assign job      = jc_reg;
    assign inflight = 2'({1'b0, va_reg} + {1'b0, vb_reg} + {1'b0, vc_reg});

endmodule

`default_nettype wire

### rtl/slerp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module slerp_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire slerp_pkg::job_t             push_job,
    input  wire logic                        pop,
    output slerp_pkg::job_t                  head,
    output logic                             head_valid,
    output logic [slerp_pkg::QCNT_W-1:0]     count
);

    slerp_pkg::job_t                 mem [slerp_pkg::QUEUE_DEPTH];
    logic [slerp_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [slerp_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [slerp_pkg::QCNT_W-1:0]    count_reg;
    logic                            do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule

`default_nettype wire

### rtl/slerp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module slerp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire slerp_pkg::job_t  q_head,
    output logic                  q_pop,
    output logic                  done,
    output slerp_pkg::out_t       result
);

    slerp_pkg::back_state_t state_reg, state_next;

    logic [5:0]                   cnt_reg, cnt_next;
    slerp_pkg::job_t              job_reg, job_next;
    logic [61:0]                  sq_n_reg, sq_n_next;
    logic [61:0]                  sq_res_reg, sq_res_next;
    logic [61:0]                  sq_bit_reg, sq_bit_next;
    logic signed [33:0]           x_reg [2];
    logic signed [33:0]           x_next [2];
    logic signed [33:0]           y_reg [2];
    logic signed [33:0]           y_next [2];
    logic signed [32:0]           z_reg [2];
    logic signed [32:0]           z_next [2];
    logic [31:0]                  t_reg, t_next;
    logic [31:0]                  rem_reg [2];
    logic [31:0]                  rem_next [2];
    logic [slerp_pkg::QB-1:0]     nsh_reg [2];
    logic [slerp_pkg::QB-1:0]     nsh_next [2];
    logic [slerp_pkg::QB-1:0]     q_reg [2];
    logic [slerp_pkg::QB-1:0]     q_next [2];
    logic                         sgn_reg [2];
    logic                         sgn_next [2];
    logic signed [39:0]           w_reg [2];
    logic signed [39:0]           w_next [2];
    logic signed [63:0]           acc_reg, acc_next;
    logic [1:0]                   comp_reg, comp_next;
    logic [2:0]                   step_reg, step_next;
    logic [3:0][15:0]             outv_reg, outv_next;
    logic                         done_reg, done_next;
    slerp_pkg::out_t              res_reg, res_next;

    logic                         iter_last;
    logic [4:0]                   idx;
    logic [30:0]                  s_val;
    logic [61:0]                  sq_sum;
    logic [31:0]                  t_cl;
    logic [62:0]                  mprod;
    logic signed [33:0]           dx;
    logic signed [33:0]           dy;
    logic [32:0]                  atan_v;
    logic [33:0]                  ymag;
    logic [31:0]                  rt;
    logic signed [16:0]           opd;
    logic signed [20:0]           mop;
    logic signed [39:0]           wsel;
    logic signed [37:0]           mac_p;
    logic signed [63:0]           addend;
    logic signed [63:0]           vfin;
    logic [15:0]                  vsat;

    assign idx       = cnt_reg[4:0];
    assign iter_last = (cnt_reg == 6'(slerp_pkg::ANGLE_ITERATIONS - 1));
    assign s_val     = sq_res_reg[30:0];
    assign t_cl      = z_reg[0][32] ? 32'd0 : z_reg[0][31:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            slerp_pkg::B_IDLE:  if (q_valid) state_next = slerp_pkg::B_SQRT;
            slerp_pkg::B_SQRT:  if (cnt_reg == 6'd30) state_next = slerp_pkg::B_SEL;
            slerp_pkg::B_SEL:
            begin
                if (job_reg.lin || (s_val == '0))
                    state_next = slerp_pkg::B_MAC;
                else
                    state_next = slerp_pkg::B_VEC;
            end
            slerp_pkg::B_VEC:   if (iter_last) state_next = slerp_pkg::B_MULA;
            slerp_pkg::B_MULA:  state_next = slerp_pkg::B_MULB;
            slerp_pkg::B_MULB:  state_next = slerp_pkg::B_ROT;
            slerp_pkg::B_ROT:   if (iter_last) state_next = slerp_pkg::B_DINIT;
            slerp_pkg::B_DINIT: state_next = slerp_pkg::B_DIV;
            slerp_pkg::B_DIV:
            begin
                if (cnt_reg == 6'(slerp_pkg::QB - 1))
                    state_next = slerp_pkg::B_WGT;
            end
            slerp_pkg::B_WGT:   state_next = slerp_pkg::B_MAC;
            slerp_pkg::B_MAC:
            begin
                if ((comp_reg == 2'd3) && (step_reg == 3'd4))
                    state_next = slerp_pkg::B_OUT;
            end
            slerp_pkg::B_OUT:   state_next = slerp_pkg::B_IDLE;
            default:            state_next = slerp_pkg::B_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        cnt_next    = '0;
        job_next    = job_reg;
        sq_n_next   = sq_n_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        t_next      = t_reg;
        rem_next    = rem_reg;
        nsh_next    = nsh_reg;
        q_next      = q_reg;
        sgn_next    = sgn_reg;
        w_next      = w_reg;
        acc_next    = acc_reg;
        comp_next   = comp_reg;
        step_next   = step_reg;
        outv_next   = outv_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        q_pop       = 1'b0;
        sq_sum      = '0;
        mprod       = '0;
        dx          = '0;
        dy          = '0;
        atan_v      = 33'(slerp_pkg::atan_entry(idx));
        ymag        = '0;
        rt          = '0;
        opd         = '0;
        mop         = '0;
        wsel        = '0;
        mac_p       = '0;
        addend      = '0;
        vfin        = '0;
        vsat        = '0;

        unique case (state_reg)
            slerp_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    job_next    = q_head;
                    sq_n_next   = 62'(q_head.n);
                    sq_res_next = '0;
                    sq_bit_next = 62'(1) << 60;
                end
            end

            // Floor square root, one result bit per cycle.
            slerp_pkg::B_SQRT:
            begin
                sq_sum = sq_res_reg + sq_bit_reg;
                if (sq_n_reg >= sq_sum)
                begin
                    sq_n_next   = sq_n_reg - sq_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next = (cnt_reg == 6'd30) ? 6'd0 : cnt_reg + 6'd1;
            end

            slerp_pkg::B_SEL:
            begin
                x_next[0] = 34'(job_reg.c);
                y_next[0] = 34'(s_val);
                z_next[0] = '0;
                w_next[0] = 40'(slerp_pkg::QONE - job_reg.r30);
                w_next[1] = 40'(job_reg.r30);
                acc_next  = 64'(1) <<< 29;
                comp_next = '0;
                step_next = '0;
            end

            // Vectoring: theta = atan2(sin, cos).
            slerp_pkg::B_VEC:
            begin
                dx = y_reg[0] >>> idx;
                dy = x_reg[0] >>> idx;
                if (y_reg[0] > 0)
                begin
                    x_next[0] = x_reg[0] + dx;
                    y_next[0] = y_reg[0] - dy;
                    z_next[0] = z_reg[0] + $signed(atan_v);
                end
                else
                begin
                    x_next[0] = x_reg[0] - dx;
                    y_next[0] = y_reg[0] + dy;
                    z_next[0] = z_reg[0] - $signed(atan_v);
                end
                cnt_next = iter_last ? 6'd0 : cnt_reg + 6'd1;
            end

            slerp_pkg::B_MULA:
            begin
                t_next    = t_cl;
                mprod     = 63'(t_cl) * 63'(slerp_pkg::QONE - job_reg.r30);
                z_next[1] = 33'(mprod >> 30);
            end

            slerp_pkg::B_MULB:
            begin
                mprod     = 63'(t_reg) * 63'(job_reg.r30);
                z_next[0] = z_reg[1];
                z_next[1] = 33'(mprod >> 30);
                for (int l = 0; l < 2; l++)
                begin
                    x_next[l] = slerp_pkg::CORDIC_KINV;
                    y_next[l] = '0;
                end
            end

            // Rotation: both partial-angle sines side by side.
            slerp_pkg::B_ROT:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    if (z_reg[l] >= 0)
                    begin
                        x_next[l] = x_reg[l] - (y_reg[l] >>> idx);
                        y_next[l] = y_reg[l] + (x_reg[l] >>> idx);
                        z_next[l] = z_reg[l] - $signed(atan_v);
                    end
                    else
                    begin
                        x_next[l] = x_reg[l] + (y_reg[l] >>> idx);
                        y_next[l] = y_reg[l] - (x_reg[l] >>> idx);
                        z_next[l] = z_reg[l] + $signed(atan_v);
                    end
                end
                cnt_next = iter_last ? 6'd0 : cnt_reg + 6'd1;
            end

            slerp_pkg::B_DINIT:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    ymag        = y_reg[l][33] ? 34'(-y_reg[l]) : 34'(y_reg[l]);
                    sgn_next[l] = y_reg[l][33];
                    rem_next[l] = 32'(ymag >> (slerp_pkg::QB - 30));
                    nsh_next[l] = slerp_pkg::QB'({ymag, 30'd0});
                    q_next[l]   = '0;
                end
            end

            // Restoring division of sin * 2^30 by sin(theta), both lanes.
            slerp_pkg::B_DIV:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rt = {rem_reg[l][30:0], nsh_reg[l][slerp_pkg::QB-1]};
                    if (rt >= 32'(s_val))
                    begin
                        rem_next[l] = rt - 32'(s_val);
                        q_next[l]   = {q_reg[l][slerp_pkg::QB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = rt;
                        q_next[l]   = {q_reg[l][slerp_pkg::QB-2:0], 1'b0};
                    end
                    nsh_next[l] = nsh_reg[l] << 1;
                end
                cnt_next = (cnt_reg == 6'(slerp_pkg::QB - 1)) ? 6'd0 : cnt_reg + 6'd1;
            end

            slerp_pkg::B_WGT:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    w_next[l] = sgn_reg[l] ? -40'(q_reg[l]) : 40'(q_reg[l]);
                end
                acc_next  = 64'(1) <<< 29;
                comp_next = '0;
                step_next = '0;
            end

            // Weighted sum: four partial products per component, then round
            // and saturate.
            slerp_pkg::B_MAC:
            begin
                if (step_reg == 3'd4)
                begin
                    vfin = acc_reg >>> 30;
                    if (vfin > slerp_pkg::OUT_HI)
                        vsat = 16'(slerp_pkg::OUT_HI);
                    else if (vfin < slerp_pkg::OUT_LO)
                        vsat = 16'(slerp_pkg::OUT_LO);
                    else
                        vsat = vfin[15:0];
                    outv_next[comp_reg] = vsat;
                    acc_next  = 64'(1) <<< 29;
                    step_next = '0;
                    comp_next = comp_reg + 2'd1;
                end
                else
                begin
                    opd  = step_reg[1] ? $signed(job_reg.b[comp_reg])
                                       : 17'($signed(job_reg.a[comp_reg]));
                    wsel = step_reg[1] ? w_reg[1] : w_reg[0];
                    mop  = step_reg[0] ? $signed({wsel[39], wsel[39:20]})
                                       : $signed({1'b0, wsel[19:0]});
                    mac_p  = mop * opd;
                    addend = step_reg[0] ? (64'(mac_p) <<< 20) : 64'(mac_p);
                    acc_next  = acc_reg + addend;
                    step_next = step_reg + 3'd1;
                end
            end

            slerp_pkg::B_OUT:
            begin
                done_next = 1'b1;
                res_next.out_w = $signed(outv_reg[0]);
                res_next.out_x = $signed(outv_reg[1]);
                res_next.out_y = $signed(outv_reg[2]);
                res_next.out_z = $signed(outv_reg[3]);
            end

            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slerp_pkg::B_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        sq_n_reg   <= sq_n_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        t_reg      <= t_next;
        rem_reg    <= rem_next;
        nsh_reg    <= nsh_next;
        q_reg      <= q_next;
        sgn_reg    <= sgn_next;
        w_reg      <= w_next;
        acc_reg    <= acc_next;
        outv_reg   <= outv_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Fixed-point constants of the interpolation arithmetic, all in Q.30.
    localparam longint ONE_Q30    = 64'sd1 << 30;
    localparam longint NEAR_Q30   = 64'sd1073742;
    localparam longint GAIN_INV   = 64'sd652032874;
    localparam int     ITER_COUNT = (slerp_pkg::ANGLE_ITERATIONS > 32) ? 32
                                    : slerp_pkg::ANGLE_ITERATIONS;
    localparam int     RANDOM_TXNS = 1500;

    // Idle time after the final drain. It is generous against a back-end pass
    // for the spherical case plus the longest sender gap.
    localparam int     SETTLE_CYCLES = 400;

    // Arctangent of 2^-i, Q.30 radians.
    localparam longint ATAN_LUT [32] = '{
        843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1, 0
    };

    // Floor division by a power of two. The >>> operator on a signed
    // longint is already a floor shift.
    function automatic longint floor_shift(input longint v, input int n);
        return v >>> n;
    endfunction

    // Floor square root of an unsigned 64-bit value, bit by bit.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    -= root + bitv;
                root  = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Vectoring CORDIC: angle of the vector (x, y) for x >= 0.
    function automatic longint vector_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < ITER_COUNT; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += ATAN_LUT[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= ATAN_LUT[i];
            end
        end
        return z;
    endfunction

    // Rotation CORDIC: sine of an angle in [0, pi/2].
    function automatic longint rotate_sine(input longint ang);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = GAIN_INV;
        y = 0;
        z = ang;
        for (int i = 0; i < ITER_COUNT; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ATAN_LUT[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ATAN_LUT[i];
            end
        end
        return y;
    endfunction

    // Computes the interpolated quaternion that the block should return for
    // one input transaction.
    function automatic slerp_pkg::out_t slerp_predict(input slerp_pkg::in_t q);
        longint          a [4];
        longint          b [4];
        longint          dot;
        longint unsigned mag;
        longint unsigned ratio;
        longint          cosv;
        longint          r30;
        longint          w_from;
        longint          w_to;
        longint          sinv;
        longint          theta;
        longint          ang_from;
        longint          ang_to;
        longint          hi;
        longint          lo;
        longint          v;
        logic [3:0][15:0] res;
        a[0] = q.from_w;   a[1] = q.from_x;   a[2] = q.from_y;   a[3] = q.from_z;
        b[0] = q.target_w; b[1] = q.target_x; b[2] = q.target_y; b[3] = q.target_z;
        dot = 0;
        for (int k = 0; k < 4; k++)
            dot += a[k] * b[k];
        // Negative dot product: flip the target so the shorter arc is taken.
        if (dot < 0)
        begin
            dot = -dot;
            for (int k = 0; k < 4; k++)
                b[k] = -b[k];
        end
        mag = dot;
        if (2 * slerp_pkg::FRAC_BITS <= 30)
            mag <<= (30 - 2 * slerp_pkg::FRAC_BITS);
        else
            mag >>= (2 * slerp_pkg::FRAC_BITS - 30);
        if (mag > ONE_Q30)
            mag = ONE_Q30;
        cosv = mag;

        ratio = q.blend;
        if (ratio > (64'd1 << slerp_pkg::FRAC_BITS))
            ratio = 64'd1 << slerp_pkg::FRAC_BITS;
        r30 = ratio << (30 - slerp_pkg::FRAC_BITS);

        w_from = ONE_Q30 - r30;
        w_to   = r30;
        if (ONE_Q30 - cosv > NEAR_Q30)
        begin
            sinv = floor_sqrt((64'd1 << 60) - mag * mag);
            if (sinv > 0)
            begin
                theta = vector_angle(cosv, sinv);
                if (theta < 0)
                    theta = 0;
                ang_from = (longint'(theta) * (ONE_Q30 - r30)) >>> 30;
                ang_to   = (longint'(theta) * r30) >>> 30;
                w_from   = (rotate_sine(ang_from) * ONE_Q30) / sinv;
                w_to     = (rotate_sine(ang_to) * ONE_Q30) / sinv;
            end
        end

        hi = (slerp_pkg::FRAC_BITS >= 15) ? 32767 : (64'sd1 << slerp_pkg::FRAC_BITS);
        lo = (slerp_pkg::FRAC_BITS >= 15) ? -32768 : -(64'sd1 << slerp_pkg::FRAC_BITS);
        for (int k = 0; k < 4; k++)
        begin
            v = floor_shift(w_from * a[k] + w_to * b[k] + (64'sd1 << 29), 30);
            if (v > hi)
                v = hi;
            if (v < lo)
                v = lo;
            res[3 - k] = v[15:0];
        end
        return slerp_pkg::out_t'(res);
    endfunction

    // Scoreboard: keeps the quaternions still owed by the block in order.
    class slerp_scoreboard;
        slerp_pkg::out_t pending_quats[$];
        int              fail_count;

        function new();
            fail_count = 0;
        endfunction

        function void note_input(input slerp_pkg::in_t q);
            pending_quats.push_back(slerp_predict(q));
        endfunction

        function void check_result(input slerp_pkg::out_t got);
            slerp_pkg::out_t exp_q;
            if (pending_quats.size() == 0)
            begin
                $error("result %h arrived with nothing outstanding", got);
                fail_count++;
                return;
            end
            exp_q = pending_quats.pop_front();
            if (got.out_w !== exp_q.out_w)
            begin
                $error("out_w expected %0d actual %0d", exp_q.out_w, got.out_w);
                fail_count++;
            end
            if (got.out_x !== exp_q.out_x)
            begin
                $error("out_x expected %0d actual %0d", exp_q.out_x, got.out_x);
                fail_count++;
            end
            if (got.out_y !== exp_q.out_y)
            begin
                $error("out_y expected %0d actual %0d", exp_q.out_y, got.out_y);
                fail_count++;
            end
            if (got.out_z !== exp_q.out_z)
            begin
                $error("out_z expected %0d actual %0d", exp_q.out_z, got.out_z);
                fail_count++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            start;
    slerp_pkg::in_t  item;
    logic            busy;
    logic            done;
    slerp_pkg::out_t result;

    slerp_scoreboard quat_board;

    quaternion_slerp DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Results cannot be held off, so every strobe is checked at the edge
    // that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            quat_board.check_result(result);
    end

    // A random component: mostly within the unit range, sometimes at its
    // extremes, and now and then any 16-bit value so every bit toggles.
    function automatic logic [15:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'($urandom);
        else if (sel == 1)
            return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // A random ratio: usually in range, occasionally above one so that the
    // clamp is exercised, and the ends of the range now and then.
    function automatic logic [14:0] rand_blend();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 15'($urandom);
        else if (sel == 1)
            return ($urandom_range(0, 1) != 0) ? 15'd16384 : 15'd0;
        return 15'($urandom_range(0, 16384));
    endfunction

    // A near-unit quaternion: a random direction scaled to length one.
    function automatic slerp_pkg::in_t rand_pair(input bit near_pair);
        slerp_pkg::in_t q;
        real            f [4];
        real            t [4];
        real            norm;
        for (int k = 0; k < 4; k++)
            f[k] = $itor($signed($urandom_range(0, 2000)) - 1000) + 0.5;
        norm = $sqrt(f[0]*f[0] + f[1]*f[1] + f[2]*f[2] + f[3]*f[3]);
        for (int k = 0; k < 4; k++)
        begin
            f[k] = f[k] / norm;
            // A near pair sits a few codes off the start; otherwise a fresh
            // direction. Either is sometimes flipped to force the shorter-arc fold.
            if (near_pair)
                t[k] = f[k] + ($itor($urandom_range(0, 20)) - 10.0) / 16384.0;
            else
                t[k] = $itor($signed($urandom_range(0, 2000)) - 1000) / 1000.0;
        end
        if (!near_pair)
        begin
            norm = $sqrt(t[0]*t[0] + t[1]*t[1] + t[2]*t[2] + t[3]*t[3]) + 1e-9;
            for (int k = 0; k < 4; k++)
                t[k] = t[k] / norm;
        end
        if ($urandom_range(0, 3) == 0)
            for (int k = 0; k < 4; k++)
                t[k] = -t[k];
        q.from_w   = 16'($rtoi(f[0] * 16384.0));
        q.from_x   = 16'($rtoi(f[1] * 16384.0));
        q.from_y   = 16'($rtoi(f[2] * 16384.0));
        q.from_z   = 16'($rtoi(f[3] * 16384.0));
        q.target_w = 16'($rtoi(t[0] * 16384.0));
        q.target_x = 16'($rtoi(t[1] * 16384.0));
        q.target_y = 16'($rtoi(t[2] * 16384.0));
        q.target_z = 16'($rtoi(t[3] * 16384.0));
        q.blend    = rand_blend();
        return q;
    endfunction

    function automatic slerp_pkg::in_t rand_noise();
        slerp_pkg::in_t q;
        q.from_w   = rand_comp();
        q.from_x   = rand_comp();
        q.from_y   = rand_comp();
        q.from_z   = rand_comp();
        q.target_w = rand_comp();
        q.target_x = rand_comp();
        q.target_y = rand_comp();
        q.target_z = rand_comp();
        q.blend    = rand_blend();
        return q;
    endfunction

    function automatic slerp_pkg::in_t make_quat(input int fw, fx, fy, fz, tw, tx, ty, tz,
                                                 r);
        slerp_pkg::in_t q;
        q.from_w   = 16'(fw);
        q.from_x   = 16'(fx);
        q.from_y   = 16'(fy);
        q.from_z   = 16'(fz);
        q.target_w = 16'(tw);
        q.target_x = 16'(tx);
        q.target_y = 16'(ty);
        q.target_z = 16'(tz);
        q.blend    = 15'(r);
        return q;
    endfunction

    // Presents one transaction and holds it until the block takes it. When
    // allow_gap is set, a random burst of idle cycles may come first.
    task automatic send_quat(input slerp_pkg::in_t q, input bit allow_gap);
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17))
                @(posedge clk);
        end
        start <= 1'b1;
        item  <= q;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        quat_board.note_input(q);
    endtask

    // Lowers start and waits until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (quat_board.pending_quats.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        slerp_pkg::in_t q;
        quat_board = new();
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: identical quaternions (near-parallel), opposite
        // signs (shorter-arc fold), orthogonal pairs, ratio at zero, one and
        // above one, saturated dot product and saturated outputs from
        // non-unit inputs, and zero quaternions with a zero dot product.
        send_quat(make_quat(16384, 0, 0, 0, 16384, 0, 0, 0, 8192), 1'b0);
        send_quat(make_quat(16384, 0, 0, 0, -16384, 0, 0, 0, 4096), 1'b0);
        send_quat(make_quat(16384, 0, 0, 0, 0, 16384, 0, 0, 0), 1'b0);
        send_quat(make_quat(16384, 0, 0, 0, 0, 16384, 0, 0, 16384), 1'b0);
        send_quat(make_quat(0, 0, 16384, 0, 0, 0, 0, 16384, 8192), 1'b0);
        send_quat(make_quat(11585, 11585, 0, 0, 16384, 0, 0, 0, 8192), 1'b0);
        send_quat(make_quat(11585, 11585, 0, 0, 0, 0, -11585, -11585, 12000), 1'b0);
        send_quat(make_quat(16384, 0, 0, 0, 0, 16384, 0, 0, 32767), 1'b0);
        send_quat(make_quat(16384, 0, 0, 0, 16384, 0, 0, 0, 20000), 1'b0);
        send_quat(make_quat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            8192), 1'b0);
        send_quat(make_quat(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                            3000), 1'b0);
        send_quat(make_quat(32767, -32768, 0, 0, 0, 0, 32767, -32768, 8192), 1'b0);
        send_quat(make_quat(0, 0, 0, 0, 0, 0, 0, 0, 8192), 1'b0);
        send_quat(make_quat(16384, 0, 0, 0, 16383, 181, 0, 0, 8192), 1'b0);
        send_quat(make_quat(16384, 0, 0, 0, 16370, 600, 0, 0, 5000), 1'b0);
        send_quat(make_quat(-16384, 0, 0, 0, 0, 0, 0, -16384, 1), 1'b0);
        send_quat(make_quat(8192, 8192, 8192, 8192, -8192, 8192, -8192, 8192, 16383),
                  1'b0);

        // The sender holds off here until the block has returned everything.
        drain_results();

        // Random part: mostly unit pairs, some near-parallel, some noise.
        // Gaps only in the first part; the tail runs back to back.
        for (int n = 0; n < RANDOM_TXNS; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    q = rand_noise();
                2, 3:    q = rand_pair(1'b1);
                default: q = rand_pair(1'b0);
            endcase
            send_quat(q, n < RANDOM_TXNS - 200);
            if (n == RANDOM_TXNS / 2)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (quat_board.fail_count == 0 && quat_board.pending_quats.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Safety net against a hang: far beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
